>>> src/uart_line_editor_fifo_unit_macros.svh
// assertion macros shared by the checker
`ifndef UART_LINE_EDITOR_FIFO_UNIT_MACROS_SVH
`define UART_LINE_EDITOR_FIFO_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ULE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ULE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ule_pkg.sv
package ule_pkg;

	// buffer geometry
	localparam int BUFFER_DEPTH = 256;
	localparam int LINE_MAX     = 128;
	localparam int IDX_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int POS_W        = $clog2(LINE_MAX + 1);

	// character codes
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;

	// command codes
	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_DRAIN   = 1'b1;

	// configuration register indexes
	localparam logic REG_MIN_PRINTABLE = 1'b0;
	localparam logic REG_MAX_PRINTABLE = 1'b1;

	// register reset values
	localparam logic [7:0] MIN_PRINTABLE_RST = 8'd32;
	localparam logic [7:0] MAX_PRINTABLE_RST = 8'd126;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} ule_item_t;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic       echo_valid;
		logic [7:0] line_byte;
		logic       line_valid;
		logic       line_end;
		logic [7:0] line_length;
		logic       last;
	} ule_result_t;

	// echo sequence handed from editor to emitter, seq[0] goes out first
	typedef struct packed {
		logic            load;
		logic [1:0]      cnt;
		logic [2:0][7:0] seq;
	} ule_echo_job_t;

	// drain request waiting for its memory read
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [POS_W-1:0] len;
	} ule_drain_t;

endpackage

>>> src/uart_line_editor_fifo_unit.sv
// the first result of a request shows in the cycle after start is taken
// throughput: one request per cycle for drains and single-echo bytes; CR and
//   backspace/DEL keep busy high until the last character of their one-per-cycle echo
// each result is on the ports for one cycle with done high, no stall from the receiver
// reset: arst_n clears indexes, counts and flags and restores the printable range
module uart_line_editor_fifo_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ule_pkg::ule_item_t   item,
	output ule_pkg::ule_result_t result,
	output logic                 done,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);

	logic                      accept;
	logic                      ram_we, ram_re;
	logic [ule_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]                ram_wdata, rd_data;
	ule_pkg::ule_echo_job_t    echo_job;
	ule_pkg::ule_drain_t       drain_s1;

	// request handshake
	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	ule_editor u_editor (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_data   (rd_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.echo_job  (echo_job),
		.drain_s1  (drain_s1)
	);

	// ring buffer storage
	ule_ram #(
		.WIDTH (8),
		.DEPTH (ule_pkg::BUFFER_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	ule_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.echo_job (echo_job),
		.drain_s1 (drain_s1),
		.rd_data  (rd_data),
		.result   (result),
		.done     (done),
		.busy     (busy)
	);

endmodule

>>> src/ule_ram.sv
module ule_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/ule_editor.sv
module ule_editor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  ule_pkg::ule_item_t     item,
	input  logic                   cfg_write,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_data,
	input  logic [7:0]             rd_data,
	output logic                   ram_we,
	output logic [ule_pkg::IDX_W-1:0] ram_waddr,
	output logic [7:0]             ram_wdata,
	output logic                   ram_re,
	output logic [ule_pkg::IDX_W-1:0] ram_raddr,
	output ule_pkg::ule_echo_job_t echo_job,
	output ule_pkg::ule_drain_t    drain_s1
);

	logic [7:0]                min_q, max_q;
	logic [ule_pkg::IDX_W-1:0] wr_idx_q, rd_idx_q, wr_idx_d, rd_idx_d;
	logic [ule_pkg::CNT_W-1:0] fill_q, cursor_q, fill_d, cursor_d;
	logic                      prev_cr_q, prev_cr_d;
	logic [ule_pkg::POS_W-1:0] pos_q, pos_d, pos_eff, pos_inc;
	logic                      pos_clr;
	logic                      not_full;
	logic                      push;
	logic [7:0]                push_byte;
	ule_pkg::ule_drain_t       drain_d;
	logic [7:0]                c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= ule_pkg::MIN_PRINTABLE_RST;
			max_q <= ule_pkg::MAX_PRINTABLE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ule_pkg::REG_MIN_PRINTABLE: min_q <= cfg_data;
				ule_pkg::REG_MAX_PRINTABLE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// forward a terminator seen on the read data into the line position
	assign pos_clr = drain_s1.valid && drain_s1.hit && (rd_data == 8'h00);
	assign pos_eff = pos_clr ? '0 : pos_q;
	assign pos_inc = (pos_eff < ule_pkg::POS_W'(ule_pkg::LINE_MAX)) ?
		pos_eff + 1'b1 : pos_eff;

	assign not_full = (fill_q != ule_pkg::CNT_W'(ule_pkg::BUFFER_DEPTH));
	assign c        = item.rx_byte;

	// request decode and state update
	always_comb begin
		wr_idx_d  = wr_idx_q;
		rd_idx_d  = rd_idx_q;
		fill_d    = fill_q;
		cursor_d  = cursor_q;
		prev_cr_d = prev_cr_q;
		pos_d     = pos_eff;
		push      = 1'b0;
		push_byte = 8'h00;
		ram_re    = 1'b0;
		drain_d   = '0;
		echo_job  = '0;
		if (accept) begin
			if (item.command == ule_pkg::CMD_DRAIN) begin
				drain_d.valid = 1'b1;
				if (fill_q != '0) begin
					drain_d.hit = 1'b1;
					drain_d.len = pos_inc;
					ram_re      = 1'b1;
					rd_idx_d    = (rd_idx_q == ule_pkg::IDX_W'(ule_pkg::BUFFER_DEPTH - 1)) ?
						'0 : rd_idx_q + 1'b1;
					fill_d      = fill_q - 1'b1;
					pos_d       = pos_inc;
				end
			end else begin
				priority if (c == ule_pkg::CH_CR) begin
					push         = 1'b1;
					prev_cr_d    = 1'b1;
					cursor_d     = '0;
					echo_job.cnt = 2'd2;
					echo_job.seq = {8'h00, ule_pkg::CH_LF, ule_pkg::CH_CR};
				end else if (c == ule_pkg::CH_LF) begin
					push         = !prev_cr_q;
					prev_cr_d    = 1'b0;
					cursor_d     = '0;
					echo_job.cnt = 2'd1;
					echo_job.seq = {8'h00, 8'h00, ule_pkg::CH_LF};
				end else if (c == ule_pkg::CH_BS || c == ule_pkg::CH_DEL) begin
					prev_cr_d = 1'b0;
					if (cursor_q != '0) begin
						cursor_d     = cursor_q - 1'b1;
						echo_job.cnt = 2'd3;
						echo_job.seq = {ule_pkg::CH_BS, ule_pkg::CH_SP, ule_pkg::CH_BS};
						// drop the newest stored byte
						if (fill_q != '0) begin
							fill_d   = fill_q - 1'b1;
							wr_idx_d = (wr_idx_q == '0) ?
								ule_pkg::IDX_W'(ule_pkg::BUFFER_DEPTH - 1) : wr_idx_q - 1'b1;
						end
					end
				end else if (c >= min_q && c <= max_q) begin
					prev_cr_d    = 1'b0;
					push         = 1'b1;
					push_byte    = c;
					echo_job.cnt = 2'd1;
					echo_job.seq = {8'h00, 8'h00, c};
					if (cursor_q != ule_pkg::CNT_W'(ule_pkg::BUFFER_DEPTH)) begin
						cursor_d = cursor_q + 1'b1;
					end
				end else begin
					prev_cr_d = 1'b0;
				end
				// push into the ring, dropped when full
				if (push && not_full) begin
					fill_d   = fill_q + 1'b1;
					wr_idx_d = (wr_idx_q == ule_pkg::IDX_W'(ule_pkg::BUFFER_DEPTH - 1)) ?
						'0 : wr_idx_q + 1'b1;
				end
				echo_job.load = (echo_job.cnt != 2'd0);
			end
		end
	end

	assign ram_we    = accept && (item.command == ule_pkg::CMD_RECEIVE) && push && not_full;
	assign ram_waddr = wr_idx_q;
	assign ram_wdata = push_byte;
	assign ram_raddr = rd_idx_q;

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			fill_q    <= '0;
			cursor_q  <= '0;
			prev_cr_q <= 1'b0;
			pos_q     <= '0;
			drain_s1  <= '0;
		end else begin
			wr_idx_q  <= wr_idx_d;
			rd_idx_q  <= rd_idx_d;
			fill_q    <= fill_d;
			cursor_q  <= cursor_d;
			prev_cr_q <= prev_cr_d;
			pos_q     <= pos_d;
			drain_s1  <= drain_d;
		end
	end

endmodule

>>> src/ule_emitter.sv
module ule_emitter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ule_pkg::ule_echo_job_t echo_job,
	input  ule_pkg::ule_drain_t    drain_s1,
	input  logic [7:0]             rd_data,
	output ule_pkg::ule_result_t   result,
	output logic                   done,
	output logic                   busy
);

	logic [1:0]      cnt_q;
	logic [2:0][7:0] seq_q;
	logic            is_end;

	// echo sequencer, one character per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (echo_job.load) begin
			cnt_q <= echo_job.cnt;
		end else if (cnt_q != 2'd0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (echo_job.load) begin
			seq_q <= echo_job.seq;
		end else begin
			seq_q <= {8'h00, seq_q[2:1]};
		end
	end

	assign is_end = (rd_data == 8'h00);

	// result mux, drain and echo never overlap
	always_comb begin
		result = '0;
		if (drain_s1.valid) begin
			result.last = 1'b1;
			if (drain_s1.hit) begin
				result.line_byte   = rd_data;
				result.line_valid  = 1'b1;
				result.line_end    = is_end;
				result.line_length = is_end ? 8'(drain_s1.len) : 8'h00;
			end
		end else if (cnt_q != 2'd0) begin
			result.echo_byte  = seq_q[0];
			result.echo_valid = 1'b1;
			result.last       = (cnt_q == 2'd1);
		end
	end

	assign done = drain_s1.valid || (cnt_q != 2'd0);
	assign busy = (cnt_q > 2'd1);

endmodule

>>> src/ule_checker.sv
`include "uart_line_editor_fifo_unit_macros.svh"

module ule_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input ule_pkg::ule_item_t   item,
	input ule_pkg::ule_result_t result,
	input logic                 done
);

	// a multi-character echo continues in the next cycle
	`ULE_ASSERT_NEXT(a_echo_continues, done && !result.last, done && result.echo_valid, "echo sequence broken")

	// busy only while an echo sequence is going out
	`ULE_ASSERT_NOW(a_busy_emitting, busy, done && result.echo_valid && !result.last, "busy without output")

	// a drain request gives exactly one final, non-echo result
	`ULE_ASSERT_NEXT(a_drain_result, start && !busy && item.command == ule_pkg::CMD_DRAIN, done && result.last && !result.echo_valid, "drain result missing")

	// carriage return echoes CR first and is followed by LF
	`ULE_ASSERT_NEXT(a_cr_echo, start && !busy && item.command == ule_pkg::CMD_RECEIVE && item.rx_byte == ule_pkg::CH_CR, done && result.echo_byte == ule_pkg::CH_CR && !result.last, "CR echo wrong")

	// echo and line data never share a result
	`ULE_ASSERT_NOW(a_kind_excl, done, !(result.echo_valid && result.line_valid), "mixed result kinds")

endmodule

bind uart_line_editor_fifo_unit ule_checker u_ule_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.result (result),
	.done   (done)
);
